// ===== hw/rtl/whr_pkg.sv =====
// ----------------------------------------------------------------------------
// whr_pkg: wrist raise detector shared definitions
// Register map, reset values, sequencer states and cell control types.
// ----------------------------------------------------------------------------
`default_nettype none
package whr_pkg;

	localparam int unsigned REG_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_MOTION_LIMIT = 3'd0,
		REG_X_LIMIT      = 3'd1,
		REG_Y_LIMIT      = 3'd2,
		REG_Z_LOW        = 3'd3,
		REG_Z_HIGH       = 3'd4,
		REG_SWING        = 3'd5,
		REG_TIME_WINDOW  = 3'd6
	} reg_idx_t;

	localparam logic [15:0]        RST_MOTION_LIMIT = 16'd2200;
	localparam logic [14:0]        RST_X_LIMIT      = 15'd500;
	localparam logic [14:0]        RST_Y_LIMIT      = 15'd1400;
	localparam logic signed [15:0] RST_Z_LOW        = -16'sd2000;
	localparam logic signed [15:0] RST_Z_HIGH       = -16'sd1200;
	localparam logic [15:0]        RST_SWING        = 16'd2000;
	localparam logic [31:0]        RST_TIME_WINDOW  = 32'd300;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILT,
		ST_SQ,
		ST_POS,
		ST_SCAN,
		ST_PUSH,
		ST_OUT
	} state_t;

	// one raw sample of all three axes, as held by a filter tap
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} axes_t;

	// one history entry
	typedef struct packed {
		logic signed [15:0] y;
		logic [31:0]        t;
	} hist_t;

	// control of one history cell
	typedef struct packed {
		logic shift;
		logic load;
	} hist_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/whr_in_if.sv =====
// ----------------------------------------------------------------------------
// whr_in_if: sample input channel
// Valid/ready channel carrying one accelerometer sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface whr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic [31:0]        sample_time;
	logic               turned_mode;

	modport source (output valid, accel_x, accel_y, accel_z, sample_time, turned_mode,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, sample_time, turned_mode,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/whr_out_if.sv =====
// ----------------------------------------------------------------------------
// whr_out_if: result output channel
// Valid/ready channel carrying wake and in_position per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface whr_out_if;
	logic valid;
	logic ready;
	logic wake;
	logic in_position;

	modport source (output valid, wake, in_position, input ready);
	modport sink (input valid, wake, in_position, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/whr_tap.sv =====
// ----------------------------------------------------------------------------
// whr_tap: moving average tap cell
// Holds one three-axis raw sample; takes its neighbor's sample on shift.
// ----------------------------------------------------------------------------
`default_nettype none
module whr_tap (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           shift,
	input  wire whr_pkg::axes_t nb,
	output whr_pkg::axes_t      q
);
	import whr_pkg::*;

	axes_t q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
		end else if (shift) begin
			q_q <= nb;
		end
	end

	assign q = q_q;
endmodule
`default_nettype wire

// ===== hw/rtl/whr_hist_cell.sv =====
// ----------------------------------------------------------------------------
// whr_hist_cell: history queue cell
// Holds one (y, time) entry; loads a new entry or its neighbor's on shift.
// ----------------------------------------------------------------------------
`default_nettype none
module whr_hist_cell (
	input  wire logic              clk,
	input  wire whr_pkg::hist_ctl_t ctl,
	input  wire whr_pkg::hist_t    nb,
	input  wire whr_pkg::hist_t    fresh,
	output whr_pkg::hist_t         q
);
	import whr_pkg::*;

	hist_t q_q;

	// contents are undefined until written; no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			q_q <= fresh;
		end else if (ctl.shift) begin
			q_q <= nb;
		end
	end

	assign q = q_q;
endmodule
`default_nettype wire

// ===== hw/rtl/wrist_raise_detector.sv =====
// ----------------------------------------------------------------------------
// wrist_raise_detector: accelerometer wrist raise detection
// Moving average filter, position tests and history scan for a wake event.
// ----------------------------------------------------------------------------
// Sequence: an accepted sample passes ST_DIV, ST_FILT, ST_SQ, ST_POS, ST_SCAN
//   and ST_PUSH, then the result is offered in ST_OUT; ST_SCAN consumes
//   history entries while in position, and a wake ends the scan early.
// Throughput: one sample at a time; the next is taken once the result
//   transaction completes. The history scan consumes one cell per cycle.
// Reset: arst_n clears taps, sums, queue count, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module wrist_raise_detector #(
	parameter int unsigned HISTORY_DEPTH = 16,
	parameter int unsigned FILTER_DEPTH  = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	whr_in_if.sink                              in_ch,
	whr_out_if.source                           out_ch,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [whr_pkg::REG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import whr_pkg::*;

	// filter arithmetic: sum width, and divide by FILTER_DEPTH as a
	// multiply by a rounded-up reciprocal (exact for SUM_W-bit magnitudes)
	localparam int unsigned CL     = $clog2(FILTER_DEPTH);
	localparam int unsigned SUM_W  = 16 + CL;
	localparam int unsigned SHIFT  = SUM_W + CL;
	localparam int unsigned RCP_W  = SUM_W + 1;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << SHIFT) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));
	localparam int unsigned PROD_W = SUM_W + RCP_W;
	localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(HISTORY_DEPTH);

	// ---------------- configuration registers ----------------
	logic [15:0]        motion_limit_q;
	logic [14:0]        x_limit_q;
	logic [14:0]        y_limit_q;
	logic signed [15:0] z_low_q;
	logic signed [15:0] z_high_q;
	logic [15:0]        swing_q;
	logic [31:0]        time_window_q;

	logic       cfg_wr;
	reg_idx_t   cfg_idx;
	logic [2:0] cfg_raw;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_raw = paddr[4:2];
	assign cfg_idx = reg_idx_t'(cfg_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_limit_q <= RST_MOTION_LIMIT;
			x_limit_q      <= RST_X_LIMIT;
			y_limit_q      <= RST_Y_LIMIT;
			z_low_q        <= RST_Z_LOW;
			z_high_q       <= RST_Z_HIGH;
			swing_q        <= RST_SWING;
			time_window_q  <= RST_TIME_WINDOW;
		end else if (cfg_wr) begin
			// index 7 lies beyond the register list and is dropped
			case (cfg_idx)
				REG_MOTION_LIMIT: motion_limit_q <= pwdata[15:0];
				REG_X_LIMIT:      x_limit_q      <= pwdata[14:0];
				REG_Y_LIMIT:      y_limit_q      <= pwdata[14:0];
				REG_Z_LOW:        z_low_q        <= pwdata[15:0];
				REG_Z_HIGH:       z_high_q       <= pwdata[15:0];
				REG_SWING:        swing_q        <= pwdata[15:0];
				REG_TIME_WINDOW:  time_window_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MOTION_LIMIT: prdata = {16'd0, motion_limit_q};
			REG_X_LIMIT:      prdata = {17'd0, x_limit_q};
			REG_Y_LIMIT:      prdata = {17'd0, y_limit_q};
			REG_Z_LOW:        prdata = {{16{z_low_q[15]}}, z_low_q};
			REG_Z_HIGH:       prdata = {{16{z_high_q[15]}}, z_high_q};
			REG_SWING:        prdata = {16'd0, swing_q};
			REG_TIME_WINDOW:  prdata = time_window_q;
			default:          prdata = 32'd0;
		endcase
	end

	// ---------------- sequencer ----------------
	state_t state_q, state_d;
	logic   accept;
	logic   scan_step;     // consume the oldest entry this cycle
	logic   scan_hit;      // oldest entry triggers a wake
	logic   push;

	logic [CNT_W-1:0] count_q;
	logic             wake_q;
	logic             pos_q;

	assign accept   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		scan_step = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_DIV;
			ST_DIV:  state_d = ST_FILT;
			ST_FILT: state_d = ST_SQ;
			ST_SQ:   state_d = ST_POS;
			ST_POS:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (pos_q && count_q != '0) begin
					scan_step = 1'b1;
					if (scan_hit) state_d = ST_PUSH;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				push    = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT:  if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- filter tap chain ----------------
	axes_t tap [FILTER_DEPTH];
	axes_t sample;

	assign sample.x = in_ch.accel_x;
	assign sample.y = in_ch.accel_y;
	assign sample.z = in_ch.accel_z;

	for (genvar i = 0; i < FILTER_DEPTH; i++) begin : g_tap
		whr_tap u_tap (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (accept),
			.nb    ((i == 0) ? sample : tap[(i == 0) ? 0 : i - 1]),
			.q     (tap[i])
		);
	end

	// running window sums: add the new sample, drop the one leaving the chain
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [15:0]      new_ax [3];
	logic signed [15:0]      old_ax [3];

	assign new_ax[0] = sample.x;
	assign new_ax[1] = sample.y;
	assign new_ax[2] = sample.z;
	assign old_ax[0] = tap[FILTER_DEPTH-1].x;
	assign old_ax[1] = tap[FILTER_DEPTH-1].y;
	assign old_ax[2] = tap[FILTER_DEPTH-1].z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) sum_q[a] <= '0;
		end else if (accept) begin
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= sum_q[a] + SUM_W'(new_ax[a]) - SUM_W'(old_ax[a]);
			end
		end
	end

	// ---------------- filter divide, squares, position ----------------
	logic [31:0]        now_q;
	logic               turned_q;
	logic [PROD_W-1:0]  prod_s1 [3];
	logic               neg_s1  [3];
	logic signed [15:0] f_s2    [3];
	logic [31:0]        sq_s3   [3];
	logic [31:0]        lim_sq_s3;

	logic [SUM_W-1:0]   mag_abs [3];
	logic [16:0]        quo     [3];
	logic [16:0]        quo_sn  [3];
	logic [31:0]        mag_sum;
	logic               x_ok, y_ok, z_ok;
	logic signed [16:0] fx_w, fy_w, xl_w, yl_w;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag_abs[a] = sum_q[a][SUM_W-1] ? SUM_W'(-sum_q[a]) : SUM_W'(sum_q[a]);
			quo[a]     = prod_s1[a][SHIFT +: 17];
			quo_sn[a]  = neg_s1[a] ? 17'(-quo[a]) : quo[a];
		end
	end

	assign mag_sum = sq_s3[0] + sq_s3[1] + sq_s3[2];
	assign fx_w    = 17'(f_s2[0]);
	assign fy_w    = 17'(f_s2[1]);
	assign xl_w    = signed'({2'b00, x_limit_q});
	assign yl_w    = signed'({2'b00, y_limit_q});
	assign x_ok    = (fx_w > -xl_w) && (fx_w < xl_w);
	assign y_ok    = turned_q ? ((fy_w > -yl_w) && (fy_w < 17'sd0))
	                          : ((fy_w > 17'sd0) && (fy_w < yl_w));
	assign z_ok    = (f_s2[2] > z_low_q) && (f_s2[2] < z_high_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= in_ch.sample_time;
			turned_q <= in_ch.turned_mode;
		end
		if (state_q == ST_DIV) begin
			for (int a = 0; a < 3; a++) begin
				prod_s1[a] <= PROD_W'(mag_abs[a]) * PROD_W'(RECIP);
				neg_s1[a]  <= sum_q[a][SUM_W-1];
			end
		end
		if (state_q == ST_FILT) begin
			for (int a = 0; a < 3; a++) f_s2[a] <= quo_sn[a][15:0];
		end
		if (state_q == ST_SQ) begin
			for (int a = 0; a < 3; a++) sq_s3[a] <= 32'(f_s2[a] * f_s2[a]);
			lim_sq_s3 <= motion_limit_q * motion_limit_q;
		end
	end

	// ---------------- history cell chain ----------------
	// cell 0 always holds the oldest entry; count_q entries are live
	hist_t     cell_q [HISTORY_DEPTH];
	hist_ctl_t cell_ctl [HISTORY_DEPTH];
	hist_t     fresh;
	logic      full;
	logic signed [16:0] dy;
	logic [16:0]        ady;
	logic [31:0]        age;

	assign fresh.y = f_s2[1];
	assign fresh.t = now_q;
	assign full    = (count_q == FULL);

	assign dy       = 17'(cell_q[0].y) - 17'(f_s2[1]);
	assign ady      = dy[16] ? 17'(-dy) : 17'(dy);
	assign age      = now_q - cell_q[0].t;
	assign scan_hit = (ady > {1'b0, swing_q}) && (age < time_window_q);

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
		// full queue: everything moves down and the new entry lands at the top
		assign cell_ctl[i].shift = scan_step || (push && full);
		assign cell_ctl[i].load  = push && (full ? (i == HISTORY_DEPTH - 1)
		                                         : (count_q == CNT_W'(i)));
		whr_hist_cell u_cell (
			.clk  (clk),
			.ctl  (cell_ctl[i]),
			.nb   (cell_q[(i == HISTORY_DEPTH - 1) ? i : i + 1]),
			.fresh(fresh),
			.q    (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wake_q  <= 1'b0;
			pos_q   <= 1'b0;
		end else begin
			if (state_q == ST_POS) begin
				pos_q  <= (mag_sum < lim_sq_s3) && x_ok && y_ok && z_ok;
				wake_q <= 1'b0;
			end
			if (scan_step) begin
				count_q <= count_q - 1'b1;
				if (scan_hit) wake_q <= 1'b1;
			end
			if (push && !full) count_q <= count_q + 1'b1;
		end
	end

	assign out_ch.valid       = (state_q == ST_OUT);
	assign out_ch.wake        = wake_q;
	assign out_ch.in_position = pos_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("history count above depth");

	a_wake_needs_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.wake |-> out_ch.in_position)
		else $error("wake without in_position");

	a_scan_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		scan_step |=> count_q == $past(count_q) - 1'b1)
		else $error("scan step did not consume an entry");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DIV && !in_ch.ready)
		else $error("accepted sample did not start processing");

endmodule
`default_nettype wire

// ===== verif/whr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whr_checker: wrist raise detector scoreboard
// Watches both channels and the register port, models the filter, position
// tests and history ring, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module whr_checker (
	input  logic      clk,
	input  logic      arst_n,
	whr_in_if.sink    in_mon,
	whr_out_if.sink   out_mon,
	input  logic      psel,
	input  logic      penable,
	input  logic      pwrite,
	input  logic      pready,
	input  logic [whr_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output int        fail_count,
	output int        pending,
	output int        wake_seen,
	output int        pos_seen
);
	import whr_pkg::*;

	typedef struct packed {
		logic wake;
		logic in_position;
	} verdict_t;

	localparam int RING = 16;
	localparam int TAPS = 8;

	logic [15:0]        m_motion;
	logic [14:0]        m_xlim;
	logic [14:0]        m_ylim;
	logic signed [15:0] m_zlo;
	logic signed [15:0] m_zhi;
	logic [15:0]        m_swing;
	logic [31:0]        m_window;

	logic signed [15:0] taps [3][TAPS];
	int                 tap_pos;
	hist_t              ring [RING];
	int                 head;
	int                 count;

	verdict_t verdicts [$];

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic longint avg_axis(input int axis, input logic signed [15:0] s);
		longint sum;
		sum = 0;
		taps[axis][tap_pos] = s;
		for (int i = 0; i < TAPS; i++) sum += taps[axis][i];
		return sum / TAPS;	// truncates toward zero
	endfunction

	function automatic verdict_t judge_sample(input logic signed [15:0] ax,
		input logic signed [15:0] ay, input logic signed [15:0] az,
		input logic [31:0] now, input logic turned);
		verdict_t v;
		longint fx, fy, fz, mag, ylo, yhi, d;
		hist_t e;
		fx = avg_axis(0, ax);
		fy = avg_axis(1, ay);
		fz = avg_axis(2, az);
		tap_pos = (tap_pos + 1) % TAPS;
		mag = fx * fx + fy * fy + fz * fz;
		ylo = turned ? -longint'(m_ylim) : 0;
		yhi = turned ? 0 : longint'(m_ylim);
		v.wake = 1'b0;
		v.in_position = mag < longint'(m_motion) * longint'(m_motion)
			&& fx > -longint'(m_xlim) && fx < longint'(m_xlim)
			&& fy > ylo && fy < yhi
			&& fz > longint'(m_zlo) && fz < longint'(m_zhi);
		if (v.in_position) begin
			while (count > 0 && !v.wake) begin
				e = ring[head];
				d = longint'(e.y) - fy;
				if (d < 0) d = -d;
				head = (head + 1) % RING;
				count--;
				if (d > longint'(m_swing) && (now - e.t) < m_window) v.wake = 1'b1;
			end
		end
		e.y = fy[15:0];
		e.t = now;
		if (count >= RING) begin
			ring[head] = e;
			head = (head + 1) % RING;
		end else begin
			ring[(head + count) % RING] = e;
			count++;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t got, want;
		if (!arst_n) begin
			m_motion = RST_MOTION_LIMIT;
			m_xlim   = RST_X_LIMIT;
			m_ylim   = RST_Y_LIMIT;
			m_zlo    = RST_Z_LOW;
			m_zhi    = RST_Z_HIGH;
			m_swing  = RST_SWING;
			m_window = RST_TIME_WINDOW;
			for (int a = 0; a < 3; a++)
				for (int i = 0; i < TAPS; i++) taps[a][i] = '0;
			tap_pos = 0;
			head = 0;
			count = 0;
			verdicts.delete();
			fail_count = 0;
			pending = 0;
			wake_seen = 0;
			pos_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_MOTION_LIMIT: m_motion = pwdata[15:0];
					REG_X_LIMIT:      m_xlim   = pwdata[14:0];
					REG_Y_LIMIT:      m_ylim   = pwdata[14:0];
					REG_Z_LOW:        m_zlo    = pwdata[15:0];
					REG_Z_HIGH:       m_zhi    = pwdata[15:0];
					REG_SWING:        m_swing  = pwdata[15:0];
					REG_TIME_WINDOW:  m_window = pwdata;
					default: ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				got.wake = out_mon.wake;
				got.in_position = out_mon.in_position;
				if (verdicts.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = verdicts.pop_front();
					if (got.wake !== want.wake)
						report($sformatf("wake %b, expected %b", got.wake, want.wake));
					if (got.in_position !== want.in_position)
						report($sformatf("in_position %b, expected %b",
							got.in_position, want.in_position));
					if (want.wake) wake_seen++;
					if (want.in_position) pos_seen++;
				end
			end
			if (in_mon.valid && in_mon.ready)
				verdicts.push_back(judge_sample(in_mon.accel_x, in_mon.accel_y,
					in_mon.accel_z, in_mon.sample_time, in_mon.turned_mode));
			pending = verdicts.size();
		end
	end
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: wrist raise detector testbench
// Drives samples and register writes with random idling on both channels;
// the checker scores every result transaction against its own model.
// ----------------------------------------------------------------------------
module tb_top;
	import whr_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	whr_in_if  in_ch ();
	whr_out_if out_ch ();

	logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [REG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	int fail_count, pending, wake_seen, pos_seen;
	int src_idle_pct = 0;	// chance per cycle that the sender holds off
	int snk_stall_pct = 0;	// chance per cycle that the receiver stalls
	int sent = 0;
	int quiet_cycles = 0;
	logic [31:0] clock_ms = 0;

	wrist_raise_detector dut (
		.clk, .arst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	whr_checker chk (
		.clk, .arst_n, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending, .wake_seen, .pos_seen
	);

	initial begin
		in_ch.valid = 1'b0;
		in_ch.accel_x = '0;
		in_ch.accel_y = '0;
		in_ch.accel_z = '0;
		in_ch.sample_time = '0;
		in_ch.turned_mode = 1'b0;
		out_ch.ready = 1'b0;
	end

	// receiver: ready toggles at random by the current stall rate
	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

	// watchdog: a run of cycles with no transaction on either channel ends the run
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else if (arst_n && (pending > 0 || in_ch.valid)) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction in %0d cycles", STALL_LIMIT);
				$display("wrist_raise_detector verification failed");
				$finish;
			end
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one sample transaction; valid stays high from one sample to the next unless the sender idles
	task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] z, input logic [31:0] t, input logic turned);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.accel_x <= x;
		in_ch.accel_y <= y;
		in_ch.accel_z <= z;
		in_ch.sample_time <= t;
		in_ch.turned_mode <= turned;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// a steady near-rest wrist pose around the configured bands, with a swing
	// in y on some samples, so the ring fills and wakes fire; some are plain noise
	task automatic random_sample(input int noise_pct);
		logic signed [15:0] x, y, z;
		logic turned;
		turned = 1'($urandom_range(1));
		if ($urandom_range(99) < noise_pct) begin
			x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
		end else begin
			x = 16'(int'($urandom_range(800)) - 400);
			z = 16'(-1600 + int'($urandom_range(600)) - 300);
			if ($urandom_range(3) == 0)
				y = 16'(($urandom_range(1) != 0) ? 3000 + int'($urandom_range(6000))
					: -3000 - int'($urandom_range(6000)));
			else
				y = 16'(turned ? -int'($urandom_range(1300)) - 50
					: int'($urandom_range(1300)) + 50);
		end
		// mostly short steps, occasionally a huge jump so the age wraps
		clock_ms = clock_ms + (($urandom_range(19) == 0) ? $urandom : $urandom_range(120));
		send_sample(x, y, z, clock_ms, turned);
	endtask

	initial begin
		int phase_items;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, field extremes, both orientations, in-position
		// samples, a wake, timestamp wrap and a full ring
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'hffff_ffff, 1'b1);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'h0, 1'b0);
		for (int i = 0; i < 8; i++)
			send_sample(16'sd0, 16'sd700, -16'sd1600, 32'(32'h10 + i), 1'b0);
		for (int i = 0; i < 4; i++)
			send_sample(16'sd0, -16'sd700, -16'sd1600, 32'(32'h20 + i), 1'b1);
		for (int i = 0; i < 8; i++)
			send_sample(16'sd0, 16'sh7fff, -16'sd1600, 32'(32'hffff_fff0 + i), 1'b0);
		for (int i = 0; i < 3; i++)
			send_sample(16'sd0, 16'sd700, -16'sd1600, 32'(32'h5 + i), 1'b0);
		settle();

		// configuration sweeps: extremes first, then random, then defaults
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
				default: begin src_idle_pct = 14; snk_stall_pct = 14; end
			endcase
			case (ph)
				0: begin
					reg_write(REG_MOTION_LIMIT, 32'hffff);
					reg_write(REG_X_LIMIT, 32'h7fff);
					reg_write(REG_Y_LIMIT, 32'h7fff);
					reg_write(REG_Z_LOW, 32'h8000);
					reg_write(REG_Z_HIGH, 32'h7fff);
					reg_write(REG_SWING, 32'h0);
					reg_write(REG_TIME_WINDOW, 32'hffff_ffff);
				end
				1: begin
					reg_write(REG_MOTION_LIMIT, 32'h0);
					reg_write(REG_X_LIMIT, 32'h0);
					reg_write(REG_Y_LIMIT, 32'h0);
					reg_write(REG_Z_LOW, 32'h7fff);
					reg_write(REG_Z_HIGH, 32'h8000);
					reg_write(REG_SWING, 32'hffff);
					reg_write(REG_TIME_WINDOW, 32'h0);
				end
				7: begin
					reg_write(REG_MOTION_LIMIT, 32'(RST_MOTION_LIMIT));
					reg_write(REG_X_LIMIT, 32'(RST_X_LIMIT));
					reg_write(REG_Y_LIMIT, 32'(RST_Y_LIMIT));
					reg_write(REG_Z_LOW, 32'(RST_Z_LOW));
					reg_write(REG_Z_HIGH, 32'(RST_Z_HIGH));
					reg_write(REG_SWING, 32'(RST_SWING));
					reg_write(REG_TIME_WINDOW, RST_TIME_WINDOW);
				end
				default: begin
					reg_write(REG_MOTION_LIMIT, 32'(1800 + $urandom_range(4000)));
					reg_write(REG_X_LIMIT, 32'(200 + $urandom_range(800)));
					reg_write(REG_Y_LIMIT, 32'(800 + $urandom_range(1500)));
					reg_write(REG_Z_LOW, 32'(-2400 + int'($urandom_range(600))));
					reg_write(REG_Z_HIGH, 32'(-1200 + int'($urandom_range(600))));
					reg_write(REG_SWING, 32'(1000 + $urandom_range(3000)));
					reg_write(REG_TIME_WINDOW, 32'(100 + $urandom_range(1000)));
				end
			endcase
			phase_items = 210;
			for (int i = 0; i < phase_items; i++) random_sample(15);
			settle();
		end

		$display("covered %0d samples over eight register settings", sent);
		$display("expected %0d in-position results and %0d wakes", pos_seen, wake_seen);
		if (fail_count == 0)
			$display("wrist_raise_detector verification clean");
		else
			$display("wrist_raise_detector verification failed");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/whr_pkg.sv
hw/rtl/whr_in_if.sv
hw/rtl/whr_out_if.sv
hw/rtl/whr_tap.sv
hw/rtl/whr_hist_cell.sv
hw/rtl/wrist_raise_detector.sv
verif/whr_checker.sv
verif/tb_top.sv
